// ===== rtl/core/wtv_pkg.sv =====
package wtv_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_LEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_LEN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_LEVEL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd6;

   // request opcodes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_SAMPLE  = 2'd2;

   // classified work handed to the back end
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_TRIGGER = 2'd1;
   localparam logic [1:0] KIND_SAMPLE  = 2'd2;

   localparam int LEN_W   = 24;
   localparam int LEVEL_W = 16;
   localparam int TIME_W  = 26;
   localparam int MIX_W   = 24;
   localparam int DIV_NUM_W = LEN_W + LEVEL_W;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] idx;
      logic [15:0] value;
      logic [MIX_W-1:0] mix;
   } item_type;

   typedef struct packed {
      logic [31:0]        phase_step;
      logic [LEN_W-1:0]   attack_len;
      logic [LEN_W-1:0]   decay_len;
      logic [LEN_W-1:0]   sustain_len;
      logic [LEN_W-1:0]   release_len;
      logic [LEVEL_W-1:0] peak_level;
      logic [LEVEL_W-1:0] sustain_level;
   } cfg_type;

endpackage

// ===== rtl/core/wavetable_adsr_voice_top.sv =====
// One wavetable synth voice with a linear ADSR envelope. Beats on req_ carry op 0 (write a
// table entry), op 1 (restart the note) or op 2 (one sample: mix_in plus the voice, saturated
// to 24 bits, returned on rsp_); op 3 and out-of-range table writes are dropped. A two-beat
// queue separates the decoder from the sequencer, so up to two requests are queued while the
// back end is busy. The back end handles a table write or trigger while idle; a sample steps
// through position, two table reads through the single memory port, interpolation, the
// 16-step envelope divider (attack, decay and release only), multiply, saturating sum and
// output; when no note sounds it goes straight to output. A stalled response holds the back
// end until it is taken. Write the csr_ registers only while the voice is idle.
module wavetable_adsr_voice_top #(
   parameter int TABLE_DEPTH = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [wtv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wtv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic [9:0]                      req_table_index,
   input  logic signed [15:0]              req_table_value,
   input  logic signed [23:0]              req_mix_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [23:0]              rsp_sample_out,
   output logic                            rsp_playing
);
   import wtv_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid, q_pop;
   item_type q_item;
   logic [23:0] sample_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step    <= '0;
         cfg_ff.attack_len    <= '0;
         cfg_ff.decay_len     <= '0;
         cfg_ff.sustain_len   <= '0;
         cfg_ff.release_len   <= '0;
         cfg_ff.peak_level    <= 16'hFFFF;
         cfg_ff.sustain_level <= 16'h8000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:    cfg_ff.phase_step    <= csr_wdata;
            CSR_ATTACK_LEN:    cfg_ff.attack_len    <= csr_wdata[LEN_W-1:0];
            CSR_DECAY_LEN:     cfg_ff.decay_len     <= csr_wdata[LEN_W-1:0];
            CSR_SUSTAIN_LEN:   cfg_ff.sustain_len   <= csr_wdata[LEN_W-1:0];
            CSR_RELEASE_LEN:   cfg_ff.release_len   <= csr_wdata[LEN_W-1:0];
            CSR_PEAK_LEVEL:    cfg_ff.peak_level    <= csr_wdata[LEVEL_W-1:0];
            CSR_SUSTAIN_LEVEL: cfg_ff.sustain_level <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   wtv_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_mix_in      (req_mix_in),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   wtv_back #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (sample_raw),
      .rsp_playing    (rsp_playing)
   );

   assign rsp_sample_out = signed'(sample_raw);

endmodule

// ===== rtl/core/wtv_front.sv =====
module wtv_front #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [9:0]        req_table_index,
   input  logic [15:0]       req_table_value,
   input  logic [23:0]       req_mix_in,
   output logic              q_valid,
   output wtv_pkg::item_type q_item,
   input  logic              q_pop
);
   import wtv_pkg::*;

   localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

   item_type   entry_ff [2];
   item_type   entry_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       accept, keep, push;
   logic [16:0] idx_wide;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign idx_wide  = 17'(req_table_index);

   always_comb begin
      keep = 1'b0;
      entry_in.kind  = KIND_SAMPLE;
      entry_in.idx   = idx_wide[15:0];
      entry_in.value = req_table_value;
      entry_in.mix   = req_mix_in;
      unique case (req_op)
         OP_LOAD: begin
            entry_in.kind = KIND_WRITE;
            keep = (idx_wide < DEPTH_V);   // out-of-range writes vanish here
         end
         OP_TRIGGER: begin
            entry_in.kind = KIND_TRIGGER;
            keep = 1'b1;
         end
         OP_SAMPLE: begin
            entry_in.kind = KIND_SAMPLE;
            keep = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign push    = accept && keep;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

// ===== rtl/core/wtv_div.sv =====
module wtv_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wtv_pkg::DIV_NUM_W-1:0] num,
   input  logic [wtv_pkg::LEN_W-1:0]     den,
   output logic                          busy,
   output logic [wtv_pkg::LEVEL_W-1:0]   quo
);
   import wtv_pkg::*;

   // quotient known to fit LEVEL_W bits, so the remainder starts from the top bits
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEVEL_W-1:0] shift_ff, shift_in;
   logic [4:0]         cnt_ff;
   logic               busy_ff;
   logic [LEN_W:0]     part, trial;

   assign part  = {rem_ff, shift_ff[LEVEL_W-1]};
   assign trial = part - {1'b0, den};

   always_comb begin
      if (!trial[LEN_W]) begin
         rem_in = trial[LEN_W-1:0];
      end else begin
         rem_in = part[LEN_W-1:0];
      end
      shift_in = {shift_ff[LEVEL_W-2:0], !trial[LEN_W]};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= num[DIV_NUM_W-1:LEVEL_W];
         shift_ff <= num[LEVEL_W-1:0];
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'(LEVEL_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign quo  = shift_ff;

endmodule

// ===== rtl/core/wtv_back.sv =====
module wtv_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  wtv_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  wtv_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [23:0]       rsp_sample_out,
   output logic              rsp_playing
);
   import wtv_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TW     = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
   localparam int SHIFT  = 8 + SAMPLE_BITS;
   localparam int PROD_W = 51;
   localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic signed [PROD_W:0] OUT_MAX = (PROD_W+1)'(8388607);
   localparam logic signed [PROD_W:0] OUT_MIN = -(PROD_W+1)'(8388608);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_POS  = 4'd1;
   localparam logic [3:0] S_RD0  = 4'd2;
   localparam logic [3:0] S_RD1  = 4'd3;
   localparam logic [3:0] S_W1   = 4'd4;
   localparam logic [3:0] S_INT  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_MUL  = 4'd7;
   localparam logic [3:0] S_SUM  = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   localparam logic [1:0] SEG_DIV  = 2'd0;
   localparam logic [1:0] SEG_SUS  = 2'd1;
   localparam logic [1:0] SEG_ZERO = 2'd2;

   logic [3:0] state_ff, state_in;

   logic [TW-1:0]  mem [TABLE_DEPTH];
   logic [TW-1:0]  rdata_ff;
   logic [IDX_W-1:0] rd_addr;
   logic           mem_we;

   logic [31:0]       phase_ff;
   logic [TIME_W-1:0] time_ff;
   logic              active_ff;

   logic [MIX_W-1:0]  mix_ff;
   logic [IDX_W-1:0]  i0_ff, i1_ff;
   logic [15:0]       frac_ff;
   logic signed [TW-1:0] w0_ff, w1_ff;
   logic signed [33:0] interp_ff;
   logic [1:0]        seg_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [LEN_W-1:0]  den_ff;
   logic              neg_ff;
   logic [LEVEL_W-1:0] base_ff;
   logic [LEVEL_W-1:0] env_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic              play_ff;
   logic [MIX_W-1:0]  res_ff;

   logic out_free;
   logic div_start, div_busy;
   logic [LEVEL_W-1:0] div_quo;

   // phase to table position
   logic [48:0] pos;
   logic [16:0] i0_w, i1_w;

   // envelope setup
   logic [TIME_W-1:0] t_a, t_ad, t_ads, t_total;
   logic signed [LEVEL_W+1:0] lvl_diff;
   logic [LEVEL_W-1:0] mul_a, base_in;
   logic [LEN_W-1:0]   mul_b, den_in;
   logic [1:0]         seg_in;
   logic               neg_in;
   logic               ended;

   logic signed [16:0] d_w, f_s;
   logic signed [33:0] interp_in;
   logic signed [LEVEL_W+1:0] env_sum;
   logic signed [PROD_W:0] sum;

   assign out_free = !rsp_valid || !rsp_stall;

   assign pos  = 49'(DEPTH_V) * 49'(phase_ff);
   assign i0_w = pos[48:32];
   assign i1_w = (i0_w + 17'd1 >= DEPTH_V) ? 17'd0 : i0_w + 17'd1;

   assign t_a     = TIME_W'(cfg.attack_len);
   assign t_ad    = t_a + TIME_W'(cfg.decay_len);
   assign t_ads   = t_ad + TIME_W'(cfg.sustain_len);
   assign t_total = t_ads + TIME_W'(cfg.release_len);
   assign ended   = !active_ff || (time_ff > t_total);
   assign lvl_diff = (LEVEL_W+2)'(cfg.peak_level) - (LEVEL_W+2)'(cfg.sustain_level);

   always_comb begin
      seg_in  = SEG_ZERO;
      mul_a   = cfg.peak_level;
      mul_b   = time_ff[LEN_W-1:0];
      den_in  = cfg.attack_len;
      neg_in  = 1'b0;
      base_in = '0;
      priority if (time_ff < t_a) begin
         seg_in = SEG_DIV;
      end else if (time_ff < t_ad) begin
         seg_in  = SEG_DIV;
         neg_in  = lvl_diff[LEVEL_W+1];
         mul_a   = neg_in ? LEVEL_W'(-lvl_diff) : LEVEL_W'(lvl_diff);
         mul_b   = LEN_W'(t_ad - time_ff);
         den_in  = cfg.decay_len;
         base_in = cfg.sustain_level;
      end else if (time_ff < t_ads) begin
         seg_in  = SEG_SUS;
         base_in = cfg.sustain_level;
      end else if (time_ff < t_total) begin
         seg_in = SEG_DIV;
         mul_a  = cfg.sustain_level;
         mul_b  = LEN_W'(t_total - time_ff);
         den_in = cfg.release_len;
      end else begin
         seg_in = SEG_ZERO;
      end
   end

   assign d_w = 17'(w1_ff) - 17'(w0_ff);
   assign f_s = signed'({1'b0, frac_ff});
   assign interp_in = (34'(w0_ff) <<< 16) + 34'(d_w * f_s);

   assign env_sum = neg_ff ? (LEVEL_W+2)'(base_ff) - (LEVEL_W+2)'(div_quo)
                           : (LEVEL_W+2)'(base_ff) + (LEVEL_W+2)'(div_quo);

   assign sum = (PROD_W+1)'(signed'(mix_ff)) + (PROD_W+1)'(prod_ff >>> SHIFT);

   assign div_start = (state_ff == S_RD0) && (seg_ff == SEG_DIV);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign mem_we    = q_pop && (q_item.kind == KIND_WRITE);

   always_comb begin
      unique case (state_ff)
         S_RD1:   rd_addr = i1_ff;
         default: rd_addr = i0_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[q_item.idx[IDX_W-1:0]] <= q_item.value[TW-1:0];
      rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_pop && q_item.kind == KIND_SAMPLE) state_in = S_POS;
         S_POS:  state_in = ended ? S_OUT : S_RD0;
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_W1;
         S_W1:   state_in = S_INT;
         S_INT:  state_in = S_DIV;
         S_DIV:  if (!div_busy) state_in = S_MUL;
         S_MUL:  state_in = S_SUM;
         S_SUM:  state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) mix_ff <= q_item.mix;
      if (state_ff == S_POS) begin
         i0_ff   <= i0_w[IDX_W-1:0];
         i1_ff   <= i1_w[IDX_W-1:0];
         frac_ff <= pos[31:16];
         seg_ff  <= seg_in;
         num_ff  <= DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b);
         den_ff  <= den_in;
         neg_ff  <= neg_in;
         base_ff <= base_in;
         play_ff <= !ended;
         res_ff  <= mix_ff;
      end
      if (state_ff == S_RD1) w0_ff <= signed'(rdata_ff);
      if (state_ff == S_W1)  w1_ff <= signed'(rdata_ff);
      if (state_ff == S_INT) interp_ff <= interp_in;
      if (state_ff == S_DIV && !div_busy) begin
         unique case (seg_ff)
            SEG_DIV:  env_ff <= env_sum[LEVEL_W-1:0];
            SEG_SUS:  env_ff <= base_ff;
            default:  env_ff <= '0;
         endcase
      end
      if (state_ff == S_MUL) prod_ff <= PROD_W'(interp_ff * signed'({1'b0, env_ff}));
      if (state_ff == S_SUM) begin
         if (sum > OUT_MAX) begin
            res_ff <= OUT_MAX[MIX_W-1:0];
         end else if (sum < OUT_MIN) begin
            res_ff <= OUT_MIN[MIX_W-1:0];
         end else begin
            res_ff <= sum[MIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= '0;
         time_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (q_pop && q_item.kind == KIND_TRIGGER) begin
            phase_ff  <= '0;
            time_ff   <= '0;
            active_ff <= 1'b1;
         end
         if (state_ff == S_OUT && out_free) begin
            if (play_ff) begin
               phase_ff <= phase_ff + cfg.phase_step;
               if (time_ff != TIME_MAX) time_ff <= time_ff + TIME_W'(1);
            end else begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   logic              rsp_valid_ff;
   logic [MIX_W-1:0]  rsp_sample_ff;
   logic              rsp_playing_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_sample_ff  <= res_ff;
         rsp_playing_ff <= play_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_playing    = rsp_playing_ff;

   wtv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_time_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free && play_ff) |=> (time_ff != '0))
      else $error("note time did not advance after a playing beat");

   a_silent_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !active_ff) |-> !play_ff)
      else $error("voice output while no note is active");

endmodule

// ===== tb/tb_wavetable_adsr_voice_top.sv =====
`timescale 1ns / 100ps

module tb_wavetable_adsr_voice_top;
   import wtv_pkg::*;

   localparam int DEPTH = 1024;
   localparam int STALL_LIMIT = 5000;
   localparam longint NOTE_TIME_MAX = 64'h3FFFFFF;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [9:0]  idx;
      logic [15:0] value;
      logic [23:0] mix;
   } voice_req_t;

   typedef struct {
      logic [23:0] sample;
      logic        playing;
   } voice_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = '0;
   logic [9:0] req_table_index = '0;
   logic signed [15:0] req_table_value = '0;
   logic signed [23:0] req_mix_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic rsp_playing;

   wavetable_adsr_voice_top uut (.*);

   always #5 clock = ~clock;

   // predictor state
   shortint wave_tab[DEPTH];
   logic [31:0] ph_acc, ph_step;
   longint note_t;
   bit note_on;
   logic [23:0] len_a, len_d, len_s, len_r;
   logic [15:0] lvl_peak, lvl_sus;

   voice_req_t pending_beats[$];
   voice_rsp_t expected_samples[$];
   int send_idle_pct, recv_stall_pct;
   int fail_count = 0;
   int quiet_cycles = 0;
   bit req_taken = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic longint envelope_level(longint t);
      longint a, d, s, r, tot, pk, su;
      a = len_a; d = len_d; s = len_s; r = len_r;
      tot = a + d + s + r;
      pk = lvl_peak; su = lvl_sus;
      if (t < a) return pk * t / a;
      if (t < a + d) return su + (pk - su) * (a + d - t) / d;
      if (t < a + d + s) return su;
      if (t < tot) return su * (tot - t) / r;
      return 0;
   endfunction

   function automatic voice_rsp_t next_sample(logic signed [23:0] mix);
      voice_rsp_t o;
      longint unsigned pos;
      longint tot, i0, i1, frac, w0, w1, interp, prod, res;
      o.sample = mix;
      o.playing = 1'b0;
      if (!note_on) return o;
      tot = longint'(len_a) + len_d + len_s + len_r;
      if (note_t > tot) begin
         note_on = 1'b0;
         return o;
      end
      pos = longint'(ph_acc) * DEPTH;
      i0 = pos >> 32;
      i1 = (i0 == DEPTH - 1) ? 0 : i0 + 1;
      frac = (pos >> 16) & 64'hFFFF;
      w0 = wave_tab[i0];
      w1 = wave_tab[i1];
      interp = w0 * 65536 + (w1 - w0) * frac;
      prod = interp * envelope_level(note_t);
      res = longint'(mix) + (prod >>> 24);
      if (res > 8388607) res = 8388607;
      if (res < -8388608) res = -8388608;
      o.sample = res[23:0];
      o.playing = 1'b1;
      ph_acc = ph_acc + ph_step;
      if (note_t < NOTE_TIME_MAX) note_t++;
      return o;
   endfunction

   // acceptance, prediction and checking
   always @(posedge clock) begin
      voice_rsp_t e;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_LOAD: wave_tab[req_table_index] = req_table_value;
               OP_TRIGGER: begin
                  ph_acc = '0;
                  note_t = 0;
                  note_on = 1'b1;
               end
               OP_SAMPLE: expected_samples.push_back(next_sample(req_mix_in));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("sample beat with nothing expected");
            end else begin
               e = expected_samples.pop_front();
               if (rsp_sample_out !== e.sample)
                  report_mismatch($sformatf("sample_out %0d, want %0d",
                     rsp_sample_out, $signed(e.sample)));
               if (rsp_playing !== e.playing)
                  report_mismatch($sformatf("playing %0b, want %0b", rsp_playing, e.playing));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // request driver and random response stalls
   always @(negedge clock) begin
      voice_req_t b;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (!req_valid || req_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               b = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_op <= b.op;
               req_table_index <= b.idx;
               req_table_value <= b.value;
               req_mix_in <= b.mix;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic queue_beat(logic [1:0] op, int unsigned idx, int unsigned value,
                             int unsigned mix);
      voice_req_t b;
      b.op = op; b.idx = idx[9:0]; b.value = value[15:0]; b.mix = mix[23:0];
      pending_beats.push_back(b);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_PHASE_STEP:    ph_step = data;
         CSR_ATTACK_LEN:    len_a = data[23:0];
         CSR_DECAY_LEN:     len_d = data[23:0];
         CSR_SUSTAIN_LEN:   len_s = data[23:0];
         CSR_RELEASE_LEN:   len_r = data[23:0];
         CSR_PEAK_LEVEL:    lvl_peak = data[15:0];
         CSR_SUSTAIN_LEVEL: lvl_sus = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || expected_samples.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_voice(int unsigned step, int unsigned a, int unsigned d,
                            int unsigned s, int unsigned r, int unsigned pk,
                            int unsigned su);
      write_csr(CSR_PHASE_STEP, step);
      write_csr(CSR_ATTACK_LEN, a);
      write_csr(CSR_DECAY_LEN, d);
      write_csr(CSR_SUSTAIN_LEN, s);
      write_csr(CSR_RELEASE_LEN, r);
      write_csr(CSR_PEAK_LEVEL, pk);
      write_csr(CSR_SUSTAIN_LEVEL, su);
   endtask

   task automatic set_pressure(int ph);
      case (ph % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
         default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
   endtask

   // one note: trigger, then mostly samples, with noise mixed in
   task automatic queue_note();
      longint tot;
      int n, k;
      tot = longint'(len_a) + len_d + len_s + len_r;
      n = (tot > 30) ? $urandom_range(30, 5) : int'(tot) + $urandom_range(3, 1);
      queue_beat(OP_TRIGGER, $urandom, $urandom, $urandom);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(19))
            0: queue_beat(OP_LOAD, $urandom, $urandom, $urandom);
            1: queue_beat(OP_UNUSED, $urandom, $urandom, $urandom);
            2: queue_beat(OP_TRIGGER, $urandom, $urandom, $urandom);
            default: queue_beat(OP_SAMPLE, $urandom, $urandom, $urandom);
         endcase
      end
   endtask

   initial begin
      int i, ph, m;
      ph_acc = '0; note_t = 0; note_on = 1'b0;
      ph_step = '0; len_a = '0; len_d = '0; len_s = '0; len_r = '0;
      lvl_peak = 16'hFFFF; lvl_sus = 16'h8000;
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the whole table so no unwritten entry is ever read
      for (i = 0; i < DEPTH; i++) queue_beat(OP_LOAD, i, $urandom, $urandom);
      // directed: idle samples at mix extremes, unused op, loads, zero-length note
      queue_beat(OP_SAMPLE, 0, 0, 24'h7FFFFF);
      queue_beat(OP_SAMPLE, 0, 0, 24'h800000);
      queue_beat(OP_UNUSED, 10'h3FF, 16'hFFFF, 24'hFFFFFF);
      queue_beat(OP_LOAD, 0, 16'h7FFF, 0);
      queue_beat(OP_LOAD, 1, 16'h8000, 0);
      queue_beat(OP_LOAD, 10'h3FF, 16'h7FFF, 0);
      queue_beat(OP_TRIGGER, 0, 0, 0);
      queue_beat(OP_SAMPLE, 0, 0, 24'h7FFFFF);
      queue_beat(OP_SAMPLE, 0, 0, 24'h000001);
      queue_beat(OP_SAMPLE, 0, 0, 24'h800000);
      drain();

      // full levels, max step: wraps from the last entry to entry 0, saturates
      set_voice(32'hFFFFFFFF, 1, 1, 2, 1, 16'hFFFF, 16'hFFFF);
      queue_beat(OP_TRIGGER, 0, 0, 0);
      for (i = 0; i < 8; i++) queue_beat(OP_SAMPLE, 0, 0, i[0] ? 24'h800000 : 24'h7FFFFF);
      drain();
      set_voice(32'h0, 0, 3, 0, 2, 16'hFFFF, 16'h0000);
      queue_beat(OP_TRIGGER, 0, 0, 0);
      for (i = 0; i < 7; i++) queue_beat(OP_SAMPLE, 0, 0, 24'h7FFFF0);
      drain();
      set_voice(32'h01000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                16'h0000, 16'hFFFF);
      queue_beat(OP_TRIGGER, 0, 0, 0);
      for (i = 0; i < 6; i++) queue_beat(OP_SAMPLE, 0, 0, $urandom);
      drain();

      for (ph = 0; ph < 16; ph++) begin
         set_pressure(ph);
         if (ph % 5 == 4)
            set_voice($urandom, $urandom_range(24'hFFFFFF, 24'hFFFF00), $urandom_range(4),
                      $urandom_range(4), $urandom_range(4), $urandom, $urandom);
         else
            set_voice(($urandom_range(1)) ? $urandom : $urandom_range(32'h00FFFFFF),
                      $urandom_range(6), $urandom_range(6), $urandom_range(6),
                      $urandom_range(6), $urandom, $urandom);
         for (m = 0; m < 3; m++) queue_note();
         for (m = 0; m < 2; m++) queue_beat(OP_LOAD, $urandom, $urandom, $urandom);
         drain();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
